// ----- rtl/greedy_voxel_face_mesher_defines.svh -----
// Assertion helpers used by the mesher back end.
`ifndef GREEDY_VOXEL_FACE_MESHER_DEFINES_SVH
`define GREEDY_VOXEL_FACE_MESHER_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define GVFM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GVFM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gvfm_pkg.sv -----
package gvfm_pkg;

   localparam int MAX_QUADS = 16;
   localparam int DIR_LAST  = 5;
   localparam int COLOR_W   = 24;
   localparam int OUT_W     = 5;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_ROW
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [3:0]           x;
      logic [3:0]           y;
      logic [3:0]           z;
      logic                 solid;
      logic [COLOR_W-1:0]   color;
      logic [2:0]           dir;
      logic [3:0]           slice;
      logic [3:0]           row;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RB_C,
      S_RB_N,
      S_RB_W,
      S_SC_RD,
      S_SC_CHK,
      S_W_RD,
      S_W_CHK,
      S_H_RD,
      S_H_CHK,
      S_CLR,
      S_EMIT,
      S_FIN
   } state_type;

endpackage

// ----- rtl/greedy_voxel_face_mesher.sv -----
// Channel  Ports   Direction  Moves
// request  req_*   in         voxel write or mesh-row request
// result   rsp_*   out        one quad, or the empty marker, per transfer
//
// The back end performs a voxel write as it pops it from the queue; a two-entry queue buffers requests.
// A row-0 request with a valid direction and slice rebuilds the face mask (two voxel-RAM reads
// and one mask write per cell), then scans the row like any other row.
// Row scan: each mask read takes a read state and a check state, each cleared cell a write state.
// Reset is synchronous; the mask reads as all invisible until the first rebuild.
// A stalled result stalls the back end only; requests keep queueing until the queue fills.
module greedy_voxel_face_mesher #(
   parameter int CHUNK_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [3:0]  req_voxel_x,
   input  logic [3:0]  req_voxel_y,
   input  logic [3:0]  req_voxel_z,
   input  logic [7:0]  req_voxel_kind,
   input  logic [23:0] req_voxel_color,
   input  logic [2:0]  req_face_direction,
   input  logic [3:0]  req_slice_index,
   input  logic [3:0]  req_row_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_quad_valid,
   output logic [4:0]  rsp_quad_x,
   output logic [4:0]  rsp_quad_y,
   output logic [4:0]  rsp_quad_z,
   output logic [4:0]  rsp_quad_width,
   output logic [4:0]  rsp_quad_height,
   output logic [2:0]  rsp_quad_direction,
   output logic [23:0] rsp_quad_color,
   output logic        rsp_last_of_row
);
   import gvfm_pkg::*;

   queue_head_type head;
   logic           pop;

   gvfm_front #(.CHUNK_SIZE(CHUNK_SIZE)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_voxel_x        (req_voxel_x),
      .req_voxel_y        (req_voxel_y),
      .req_voxel_z        (req_voxel_z),
      .req_voxel_kind     (req_voxel_kind),
      .req_voxel_color    (req_voxel_color),
      .req_face_direction (req_face_direction),
      .req_slice_index    (req_slice_index),
      .req_row_index      (req_row_index),
      .head               (head),
      .pop                (pop)
   );

   gvfm_back #(.CHUNK_SIZE(CHUNK_SIZE)) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quad_valid     (rsp_quad_valid),
      .rsp_quad_x         (rsp_quad_x),
      .rsp_quad_y         (rsp_quad_y),
      .rsp_quad_z         (rsp_quad_z),
      .rsp_quad_width     (rsp_quad_width),
      .rsp_quad_height    (rsp_quad_height),
      .rsp_quad_direction (rsp_quad_direction),
      .rsp_quad_color     (rsp_quad_color),
      .rsp_last_of_row    (rsp_last_of_row)
   );

endmodule

// ----- rtl/gvfm_front.sv -----
module gvfm_front #(
   parameter int CHUNK_SIZE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic [3:0]             req_voxel_x,
   input  logic [3:0]             req_voxel_y,
   input  logic [3:0]             req_voxel_z,
   input  logic [7:0]             req_voxel_kind,
   input  logic [23:0]            req_voxel_color,
   input  logic [2:0]             req_face_direction,
   input  logic [3:0]             req_slice_index,
   input  logic [3:0]             req_row_index,
   output gvfm_pkg::queue_head_type head,
   input  logic                   pop
);
   import gvfm_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    cmd_new;
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;

   always_comb begin
      cmd_new.x     = req_voxel_x;
      cmd_new.y     = req_voxel_y;
      cmd_new.z     = req_voxel_z;
      cmd_new.solid = (req_voxel_kind != 8'd0);
      cmd_new.color = req_voxel_color;
      cmd_new.dir   = req_face_direction;
      cmd_new.slice = req_slice_index;
      cmd_new.row   = req_row_index;
      if (req_mode) begin
         cmd_new.kind = CMD_ROW;
      end else if (32'(req_voxel_x) < CHUNK_SIZE && 32'(req_voxel_y) < CHUNK_SIZE &&
                   32'(req_voxel_z) < CHUNK_SIZE) begin
         cmd_new.kind = CMD_WRITE;
      end else begin
         cmd_new.kind = CMD_NOP;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/gvfm_back.sv -----
`include "greedy_voxel_face_mesher_defines.svh"

module gvfm_back #(
   parameter int CHUNK_SIZE = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gvfm_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_quad_valid,
   output logic [4:0]               rsp_quad_x,
   output logic [4:0]               rsp_quad_y,
   output logic [4:0]               rsp_quad_z,
   output logic [4:0]               rsp_quad_width,
   output logic [4:0]               rsp_quad_height,
   output logic [2:0]               rsp_quad_direction,
   output logic [23:0]              rsp_quad_color,
   output logic                     rsp_last_of_row
);
   import gvfm_pkg::*;

   localparam int CW     = $clog2(CHUNK_SIZE + 1);
   localparam int MDEPTH = CHUNK_SIZE * CHUNK_SIZE;
   localparam int VDEPTH = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
   localparam int MAW    = $clog2(MDEPTH);
   localparam int VAW    = $clog2(VDEPTH);

   function automatic logic [MAW-1:0] maddr(logic [31:0] u, logic [31:0] v);
      logic [31:0] t;
      t = u * CHUNK_SIZE + v;
      return t[MAW-1:0];
   endfunction

   function automatic logic [VAW-1:0] vaddr(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] t;
      t = (x * CHUNK_SIZE + y) * CHUNK_SIZE + z;
      return t[VAW-1:0];
   endfunction

   logic [COLOR_W:0] vmem [VDEPTH];
   logic [COLOR_W:0] mmem [MDEPTH];

   state_type        state_ff, state_in;
   cmd_type          cmd;
   logic [CW-1:0]    u_ff, u_in, v_ff, v_in, width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]    k_ff, k_in, du_ff, du_in, dv_ff, dv_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [COLOR_W:0] cell_ff, cell_in, cvox_ff, cvox_in;
   logic [2:0]       mdir_ff, mdir_in;
   logic [3:0]       mslice_ff, mslice_in;
   logic             live_ff, live_in;
   logic             pend_ff, pend_in;
   logic [4:0]       px_ff, px_in, py_ff, py_in, pz_ff, pz_in, pw_ff, pw_in, ph_ff, ph_in;
   logic [23:0]      pc_ff, pc_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rq_ff, rq_in, rl_ff, rl_in;
   logic [4:0]       rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in, rw_ff, rw_in, rh_ff, rh_in;
   logic [2:0]       rd_ff, rd_in;
   logic [23:0]      rc_ff, rc_in;

   logic             vwe, mwe;
   logic [VAW-1:0]   vwaddr, vraddr;
   logic [MAW-1:0]   mwaddr, mraddr;
   logic [COLOR_W:0] vwdata, mwdata, vrd_ff, mrd_ff;

   logic [31:0]      cx, cy, cz, nx, ny, nz, ox, oy, oz, nw;
   logic             nout, rsp_free, vis;

   assign cmd      = head.cmd;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Map (u, v, w) to x/y/z for the current sweep axes.
   always_comb begin
      nw   = mdir_ff[0] ? 32'(mslice_ff) - 32'd1 : 32'(mslice_ff) + 32'd1;
      nout = mdir_ff[0] ? (mslice_ff == 4'd0) : (nw >= CHUNK_SIZE);
      case (mdir_ff[2:1])
         2'd0: begin
            cx = 32'(mslice_ff); cy = 32'(u_ff); cz = 32'(v_ff);
            nx = nw;             ny = cy;        nz = cz;
            oy = 32'(u_ff);      oz = 32'(v_ff);
            ox = 32'(mslice_ff) + 32'(!mdir_ff[0]);
         end
         2'd1: begin
            cx = 32'(u_ff); cy = 32'(mslice_ff); cz = 32'(v_ff);
            nx = cx;        ny = nw;             nz = cz;
            ox = 32'(u_ff); oz = 32'(v_ff);
            oy = 32'(mslice_ff) + 32'(!mdir_ff[0]);
         end
         default: begin
            cx = 32'(u_ff); cy = 32'(v_ff); cz = 32'(mslice_ff);
            nx = cx;        ny = cy;        nz = nw;
            ox = 32'(u_ff); oy = 32'(v_ff);
            oz = 32'(mslice_ff) + 32'(!mdir_ff[0]);
         end
      endcase
      vis = cvox_ff[COLOR_W] && (nout || !vrd_ff[COLOR_W]);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid && cmd.kind == CMD_ROW) begin
               if (cmd.row == 4'd0) begin
                  if (32'(cmd.dir) > DIR_LAST || 32'(cmd.slice) >= CHUNK_SIZE) begin
                     state_in = S_FIN;
                  end else begin
                     state_in = S_RB_C;
                  end
               end else if (!live_ff || 32'(cmd.row) >= CHUNK_SIZE) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_SC_RD;
               end
            end
         end
         S_RB_C: state_in = S_RB_N;
         S_RB_N: state_in = S_RB_W;
         S_RB_W: begin
            if (32'(u_ff) == CHUNK_SIZE - 1 && 32'(v_ff) == CHUNK_SIZE - 1) begin
               state_in = S_SC_RD;
            end else begin
               state_in = S_RB_C;
            end
         end
         S_SC_RD: begin
            if (32'(v_ff) >= CHUNK_SIZE || cnt_ff == 5'(MAX_QUADS)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SC_CHK;
            end
         end
         S_SC_CHK: state_in = mrd_ff[COLOR_W] ? S_W_RD : S_SC_RD;
         S_W_RD: begin
            if (32'(u_ff) + 32'(width_ff) < CHUNK_SIZE) begin
               state_in = S_W_CHK;
            end else begin
               state_in = S_H_RD;
            end
         end
         S_W_CHK: state_in = (mrd_ff == cell_ff) ? S_W_RD : S_H_RD;
         S_H_RD: begin
            if (32'(v_ff) + 32'(height_ff) < CHUNK_SIZE) begin
               state_in = S_H_CHK;
            end else begin
               state_in = S_CLR;
            end
         end
         S_H_CHK: state_in = (mrd_ff != cell_ff) ? S_CLR : S_H_RD;
         S_CLR: begin
            if (dv_ff + CW'(1) == height_ff && du_ff + CW'(1) == width_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!pend_ff || rsp_free) begin
               state_in = S_SC_RD;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pop       = 1'b0;
      vwe       = 1'b0;
      vwaddr    = vaddr(32'(cmd.x), 32'(cmd.y), 32'(cmd.z));
      vwdata    = {cmd.solid, cmd.color};
      vraddr    = vaddr(cx, cy, cz);
      mwe       = 1'b0;
      mwaddr    = maddr(32'(u_ff), 32'(v_ff));
      mwdata    = '0;
      mraddr    = maddr(32'(u_ff), 32'(v_ff));
      u_in      = u_ff;      v_in      = v_ff;
      width_in  = width_ff;  height_in = height_ff;
      k_in      = k_ff;      du_in     = du_ff;     dv_in = dv_ff;
      cnt_in    = cnt_ff;    cell_in   = cell_ff;   cvox_in = cvox_ff;
      mdir_in   = mdir_ff;   mslice_in = mslice_ff; live_in = live_ff;
      pend_in   = pend_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff; pw_in = pw_ff; ph_in = ph_ff; pc_in = pc_ff;
      rq_in = rq_ff; rl_in = rl_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      rw_in = rw_ff; rh_in = rh_ff; rd_in = rd_ff; rc_in = rc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               cnt_in  = '0;
               pend_in = 1'b0;
               v_in    = '0;
               if (cmd.kind == CMD_WRITE) begin
                  vwe = 1'b1;
               end
               if (cmd.kind == CMD_ROW) begin
                  u_in = CW'(cmd.row);
                  if (cmd.row == 4'd0) begin
                     mdir_in   = cmd.dir;
                     mslice_in = cmd.slice;
                     live_in   = !(32'(cmd.dir) > DIR_LAST ||
                                   32'(cmd.slice) >= CHUNK_SIZE);
                  end
               end
            end
         end
         S_RB_C: begin
            vraddr = vaddr(cx, cy, cz);
         end
         S_RB_N: begin
            vraddr  = vaddr(nx, ny, nz);
            cvox_in = vrd_ff;
         end
         S_RB_W: begin
            mwe    = 1'b1;
            mwdata = vis ? cvox_ff : '0;
            if (32'(v_ff) == CHUNK_SIZE - 1) begin
               v_in = '0;
               u_in = (32'(u_ff) == CHUNK_SIZE - 1) ? '0 : u_ff + CW'(1);
            end else begin
               v_in = v_ff + CW'(1);
            end
         end
         S_SC_RD: begin
            mraddr = maddr(32'(u_ff), 32'(v_ff));
         end
         S_SC_CHK: begin
            if (mrd_ff[COLOR_W]) begin
               cell_in  = mrd_ff;
               width_in = CW'(1);
            end else begin
               v_in = v_ff + CW'(1);
            end
         end
         S_W_RD: begin
            mraddr    = maddr(32'(u_ff) + 32'(width_ff), 32'(v_ff));
            height_in = CW'(1);
            k_in      = '0;
         end
         S_W_CHK: begin
            if (mrd_ff == cell_ff) begin
               width_in = width_ff + CW'(1);
            end
         end
         S_H_RD: begin
            mraddr = maddr(32'(u_ff) + 32'(k_ff), 32'(v_ff) + 32'(height_ff));
            du_in  = '0;
            dv_in  = '0;
         end
         S_H_CHK: begin
            if (mrd_ff == cell_ff) begin
               if (k_ff + CW'(1) == width_ff) begin
                  k_in      = '0;
                  height_in = height_ff + CW'(1);
               end else begin
                  k_in = k_ff + CW'(1);
               end
            end
         end
         S_CLR: begin
            mwe    = 1'b1;
            mwaddr = maddr(32'(u_ff) + 32'(du_ff), 32'(v_ff) + 32'(dv_ff));
            if (dv_ff + CW'(1) == height_ff) begin
               dv_in = '0;
               du_in = du_ff + CW'(1);
            end else begin
               dv_in = dv_ff + CW'(1);
            end
         end
         S_EMIT: begin
            if (!pend_ff || rsp_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rq_in = 1'b1;  rl_in = 1'b0;
                  rx_in = px_ff; ry_in = py_ff; rz_in = pz_ff;
                  rw_in = pw_ff; rh_in = ph_ff; rd_in = mdir_ff; rc_in = pc_ff;
               end
               pend_in = 1'b1;
               px_in   = 5'(ox);
               py_in   = 5'(oy);
               pz_in   = 5'(oz);
               pw_in   = 5'(width_ff);
               ph_in   = 5'(height_ff);
               pc_in   = cell_ff[COLOR_W-1:0];
               cnt_in  = cnt_ff + 5'd1;
               v_in    = v_ff + CW'(1);
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rl_in        = 1'b1;
               rd_in        = mdir_ff;
               rq_in        = pend_ff;
               if (pend_ff) begin
                  rx_in = px_ff; ry_in = py_ff; rz_in = pz_ff;
                  rw_in = pw_ff; rh_in = ph_ff; rc_in = pc_ff;
               end else begin
                  rx_in = '0; ry_in = '0; rz_in = '0;
                  rw_in = '0; rh_in = '0; rc_in = '0;
               end
               pend_in = 1'b0;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vwaddr] <= vwdata;
      end
      vrd_ff <= vmem[vraddr];
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mmem[mwaddr] <= mwdata;
      end
      mrd_ff <= mmem[mraddr];
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;  v_ff <= v_in;  width_ff <= width_in;  height_ff <= height_in;
      k_ff <= k_in;  du_ff <= du_in;  dv_ff <= dv_in;
      cell_ff <= cell_in;  cvox_ff <= cvox_in;
      px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
      pw_ff <= pw_in;  ph_ff <= ph_in;  pc_ff <= pc_in;
      rq_ff <= rq_in;  rl_ff <= rl_in;  rx_ff <= rx_in;  ry_ff <= ry_in;
      rz_ff <= rz_in;  rw_ff <= rw_in;  rh_ff <= rh_in;  rd_ff <= rd_in;  rc_ff <= rc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mdir_ff      <= '0;
         mslice_ff    <= '0;
         live_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mdir_ff      <= mdir_in;
         mslice_ff    <= mslice_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quad_valid     = rq_ff;
   assign rsp_quad_x         = rx_ff;
   assign rsp_quad_y         = ry_ff;
   assign rsp_quad_z         = rz_ff;
   assign rsp_quad_width     = rw_ff;
   assign rsp_quad_height    = rh_ff;
   assign rsp_quad_direction = rd_ff;
   assign rsp_quad_color     = rc_ff;
   assign rsp_last_of_row    = rl_ff;

   `GVFM_ASSERT(a_cnt_max, clock, reset, cnt_ff <= 5'(MAX_QUADS), "quad count overflow")
   `GVFM_ASSERT(a_pend_cnt, clock, reset, pend_ff |-> (cnt_ff != 5'd0), "pending quad without count")
   `GVFM_ASSERT(a_fin_out, clock, reset, (state_ff == S_FIN && state_in == S_IDLE) |=> rsp_valid_ff, "row finished without result")
   `GVFM_ASSERT(a_live_dir, clock, reset, live_ff |-> (32'(mdir_ff) <= DIR_LAST), "live mask with bad direction")

endmodule

// ----- bench/greedy_voxel_face_mesher_tb.sv -----
module greedy_voxel_face_mesher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N = 16;
   localparam int LIMIT = 4000000;

   typedef struct packed {
      logic        qv;
      logic [4:0]  x;
      logic [4:0]  y;
      logic [4:0]  z;
      logic [4:0]  w;
      logic [4:0]  h;
      logic [2:0]  dir;
      logic [23:0] color;
      logic        last;
   } quad_type;

   typedef struct packed {
      logic        mode;
      logic [3:0]  x;
      logic [3:0]  y;
      logic [3:0]  z;
      logic [7:0]  kind;
      logic [23:0] color;
      logic [2:0]  dir;
      logic [3:0]  slice;
      logic [3:0]  row;
      logic        typed;
      logic [2:0]  edir;
   } req_type;

   // typed rows expect the empty result with the given direction
   localparam req_type PRE_FILL [4] = '{
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd3, 4'd9, 4'd5, 1'b1, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd7, 4'd0, 4'd0, 1'b1, 3'd7},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd2, 4'd4, 4'd3, 1'b1, 3'd7},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd6, 4'd15, 4'd0, 1'b1, 3'd6}
   };
   localparam req_type POST_FILL [17] = '{
      '{1'b0, 4'd15, 4'd15, 4'd15, 8'd255, 24'hFFFFFF, 3'd7, 4'd15, 4'd15, 1'b0, 3'd0},
      '{1'b0, 4'd0, 4'd0, 4'd0, 8'd255, 24'hFFFFFF, 3'd0, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b0, 4'd0, 4'd15, 4'd0, 8'd0, 24'h0, 3'd0, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd0, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd4, 4'd3, 4'd15, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd1, 4'd15, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd1, 4'd0, 4'd15, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd2, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd2, 4'd0, 4'd1, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd3, 4'd15, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd4, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd5, 4'd15, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd5, 4'd0, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd0, 4'd15, 4'd0, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd0, 4'd0, 4'd15, 1'b0, 3'd0},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd7, 4'd2, 4'd0, 1'b1, 3'd7},
      '{1'b1, 4'd0, 4'd0, 4'd0, 8'd0, 24'h0, 3'd7, 4'd2, 4'd9, 1'b1, 3'd7}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [3:0]  req_voxel_x = '0;
   logic [3:0]  req_voxel_y = '0;
   logic [3:0]  req_voxel_z = '0;
   logic [7:0]  req_voxel_kind = '0;
   logic [23:0] req_voxel_color = '0;
   logic [2:0]  req_face_direction = '0;
   logic [3:0]  req_slice_index = '0;
   logic [3:0]  req_row_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_quad_valid;
   logic [4:0]  rsp_quad_x;
   logic [4:0]  rsp_quad_y;
   logic [4:0]  rsp_quad_z;
   logic [4:0]  rsp_quad_width;
   logic [4:0]  rsp_quad_height;
   logic [2:0]  rsp_quad_direction;
   logic [23:0] rsp_quad_color;
   logic        rsp_last_of_row;

   greedy_voxel_face_mesher dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [31:0] voxels [N*N*N];
   logic [24:0] mask [N*N];
   logic [2:0]  mask_dir;
   logic [3:0]  mask_slice;
   quad_type    pending_quads [$];
   int          faults = 0;
   int          cycles = 0;
   int          send_idle = 0;
   int          recv_stall = 0;
   logic [23:0] palette [4] = '{24'h123456, 24'hA5A5A5, 24'hFFFFFF, 24'h000000};

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      faults++;
   endtask

   task automatic add_expected(quad_type q);
      pending_quads.insert(pending_quads.size(), q);
   endtask

   function automatic bit solid(int x, int y, int z);
      if (x < 0 || x >= N || y < 0 || y >= N || z < 0 || z >= N) return 1'b0;
      return voxels[(x*N + y)*N + z][31:24] != 0;
   endfunction

   task automatic predict_mesh_row(req_type r);
      int ua, va, wa, u, cnt, width, height;
      int c[3];
      int n[3];
      int org[3];
      bit done;
      logic [24:0] mcell;
      quad_type q;
      if (r.mode == 1'b0) begin
         voxels[(r.x*N + r.y)*N + r.z] = {r.kind, r.color};
         return;
      end
      u = int'(r.row);
      cnt = 0;
      wa = int'(mask_dir >> 1);
      ua = (wa == 0) ? 1 : 0;
      va = (wa == 2) ? 1 : 2;
      if (u == 0) begin
         mask_dir = r.dir;
         mask_slice = r.slice;
         wa = int'(mask_dir >> 1);
         ua = (wa == 0) ? 1 : 0;
         va = (wa == 2) ? 1 : 2;
         foreach (mask[i]) mask[i] = '0;
         if (mask_dir <= 5) begin
            for (int a = 0; a < N; a++)
               for (int b = 0; b < N; b++) begin
                  c[ua] = a; c[va] = b; c[wa] = int'(mask_slice);
                  n = c;
                  n[wa] += mask_dir[0] ? -1 : 1;
                  if (solid(c[0], c[1], c[2]) && !solid(n[0], n[1], n[2]))
                     mask[a*N + b] = {1'b1, voxels[(c[0]*N + c[1])*N + c[2]][23:0]};
               end
         end
      end
      if (mask_dir <= 5) begin
         for (int v = 0; v < N && cnt < 16; v++) begin
            mcell = mask[u*N + v];
            if (!mcell[24]) continue;
            width = 1;
            height = 1;
            done = 1'b0;
            while (u + width < N && mask[(u + width)*N + v] == mcell) width++;
            while (v + height < N && !done) begin
               for (int k = 0; k < width; k++)
                  if (mask[(u + k)*N + v + height] != mcell) done = 1'b1;
               if (!done) height++;
            end
            for (int du = 0; du < width; du++)
               for (int dv = 0; dv < height; dv++) mask[(u + du)*N + v + dv] = '0;
            org[ua] = u;
            org[va] = v;
            org[wa] = int'(mask_slice) + (mask_dir[0] ? 0 : 1);
            q = '{1'b1, org[0][4:0], org[1][4:0], org[2][4:0], width[4:0], height[4:0],
                  mask_dir, mcell[23:0], 1'b0};
            add_expected(q);
            cnt++;
         end
      end
      if (cnt == 0) begin
         q = '0;
         q.dir = mask_dir;
         q.last = 1'b1;
         add_expected(q);
      end else begin
         pending_quads[$].last = 1'b1;
      end
   endtask

   task automatic send(req_type r);
      quad_type q;
      @(negedge clock);
      req_valid = 1'b1;
      req_mode = r.mode;
      req_voxel_x = r.x;
      req_voxel_y = r.y;
      req_voxel_z = r.z;
      req_voxel_kind = r.kind;
      req_voxel_color = r.color;
      req_face_direction = r.dir;
      req_slice_index = r.slice;
      req_row_index = r.row;
      do @(posedge clock); while (!req_ready);
      if (r.typed) begin
         predict_mesh_row(r);
         void'(pending_quads.pop_back());
         q = '0;
         q.dir = r.edir;
         q.last = 1'b1;
         add_expected(q);
      end else begin
         predict_mesh_row(r);
      end
      if ($urandom_range(99) < send_idle) begin
         @(negedge clock);
         req_valid = 1'b0;
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
   endtask

   function automatic req_type random_write(int x, int y, int z, int style);
      req_type r;
      r = '0;
      r.mode = 1'b0;
      r.x = 4'(x);
      r.y = 4'(y);
      r.z = 4'(z);
      r.dir = 3'($urandom);
      r.slice = 4'($urandom);
      r.row = 4'($urandom);
      if (style == 0) begin
         r.kind = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         r.color = ($urandom_range(7) == 0) ? 24'($urandom) : palette[$urandom_range(1)];
      end else begin
         r.kind = (x > 2 && x < 13 && y > 1 && y < 11 && z < 12) ? 8'd255 : 8'd0;
         r.color = (z < 6) ? palette[2] : palette[3];
         if ($urandom_range(15) == 0) r.kind = 8'($urandom);
      end
      return r;
   endfunction

   task automatic fill(int style);
      for (int x = 0; x < N; x++)
         for (int y = 0; y < N; y++)
            for (int z = 0; z < N; z++) send(random_write(x, y, z, style));
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      quad_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("greedy_voxel_face_mesher_tb NOT OK");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quads.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            e = pending_quads.pop_front();
            if (rsp_quad_valid !== e.qv) report("quad_valid", rsp_quad_valid, e.qv);
            if (rsp_quad_x !== e.x) report("quad_x", rsp_quad_x, e.x);
            if (rsp_quad_y !== e.y) report("quad_y", rsp_quad_y, e.y);
            if (rsp_quad_z !== e.z) report("quad_z", rsp_quad_z, e.z);
            if (rsp_quad_width !== e.w) report("quad_width", rsp_quad_width, e.w);
            if (rsp_quad_height !== e.h) report("quad_height", rsp_quad_height, e.h);
            if (rsp_quad_direction !== e.dir) report("quad_direction", rsp_quad_direction, e.dir);
            if (rsp_quad_color !== e.color) report("quad_color", rsp_quad_color, e.color);
            if (rsp_last_of_row !== e.last) report("last_of_row", rsp_last_of_row, e.last);
         end
      end
   end

   initial begin
      req_type r;
      int items, start;
      foreach (voxels[i]) voxels[i] = '0;
      foreach (mask[i]) mask[i] = '0;
      mask_dir = '0;
      mask_slice = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (PRE_FILL[i]) send(PRE_FILL[i]);
      fill(0);
      foreach (POST_FILL[i]) send(POST_FILL[i]);

      items = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 73; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 73; end
            default: begin send_idle = 11; recv_stall = 11; end
         endcase
         if (phase == 2) fill(1);
         while (items < 50 * (phase + 1)) begin
            start = $urandom_range(99);
            if (start < 10) begin
               send(random_write($urandom_range(15), $urandom_range(15), $urandom_range(15), 0));
               items++;
            end else if (start < 20) begin
               r = '0;
               r.mode = 1'b1;
               r.dir = 3'($urandom);
               r.slice = 4'($urandom);
               r.row = 4'($urandom_range(1, 15));
               send(r);
               items++;
            end else begin
               // rebuild at row 0 then walk rows in order, sometimes cut short
               r = '0;
               r.mode = 1'b1;
               r.dir = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
               r.slice = 4'($urandom);
               for (int row = 0; row < N; row++) begin
                  r.row = 4'(row);
                  send(r);
                  items++;
                  r.dir = 3'($urandom);
                  r.slice = 4'($urandom);
                  if ($urandom_range(19) == 0) break;
               end
            end
         end
      end
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_quads.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (faults == 0)
         $display("greedy_voxel_face_mesher_tb OK");
      else
         $display("greedy_voxel_face_mesher_tb NOT OK");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/gvfm_pkg.sv
rtl/gvfm_front.sv
rtl/gvfm_back.sv
rtl/greedy_voxel_face_mesher.sv
bench/greedy_voxel_face_mesher_tb.sv
